FILE: hdl/sobg_pkg.sv
// Shared constants for the 3x3 Sobel gradient core.
package sobg_pkg;

    localparam int CFG_W   = 11;
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = 11;
    localparam int SUM_W   = 10;
    localparam int COORD_W = 10;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

FILE: hdl/sobg_ram.sv
// Simple dual-port RAM with registered read, used for the line buffers.
module sobg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/sobel_gradient_3x3_core.sv
// Top level of the streaming 3x3 Sobel gradient core with APB configuration.
//
// Takes one 8-bit gray pixel per clock, unless in_stall is high, in raster
// order and returns, for every interior pixel, its horizontal and vertical
// Sobel gradients with its row, column and an end-of-frame flag; border pixels
// produce no transaction. Sustained rate is one pixel per cycle when out_stall
// does not hold back results, set by the two line buffer RAMs, each read and
// written once per pixel. Each result passes the input stage and then the
// output register. Frame size comes from image_width and image_height, saturated
// to 3..MAX_WIDTH and 3..MAX_HEIGHT; frame_start restarts the position at (0,0).
module sobel_gradient_3x3_core
    import sobg_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PIX_W-1:0]          pixel,
    input  logic                      frame_start,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [GRAD_W-1:0]  grad_x,
    output logic signed [GRAD_W-1:0]  grad_y,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_col,
    output logic                      last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WD    = $clog2(MAX_WIDTH + 1);
    localparam int HD    = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP  = (CFG_W > WD) ? CFG_W : WD;
    localparam int HCMP  = (CFG_W > HD) ? CFG_W : HD;
    localparam int COL_OW = (CW > COORD_W) ? CW : COORD_W;
    localparam int ROW_OW = (RW > COORD_W) ? RW : COORD_W;

    logic [CFG_W-1:0]  image_width_reg;
    logic [CFG_W-1:0]  image_height_reg;
    logic [WCMP-1:0]   w_eff;
    logic [HCMP-1:0]   h_eff;

    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_next;
    logic [CW-1:0]     c_cur;
    logic [RW-1:0]     r_cur;
    logic [WCMP-1:0]   c_ext;
    logic [HCMP-1:0]   r_ext;
    logic [WCMP-1:0]   c_inc;
    logic [HCMP-1:0]   r_inc;
    logic [COL_OW-1:0] col_less;
    logic [ROW_OW-1:0] row_less;
    logic              emit;
    logic              last_pix;
    logic              accept;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [CW-1:0]     s1_idx_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic              s1_move;
    logic              out_free;

    logic              fwd_reg;
    logic [PIX_W-1:0]  fwd_above_reg;
    logic [PIX_W-1:0]  fwd_two_reg;
    logic              fwd_next;

    logic [PIX_W-1:0]  rd_above;
    logic [PIX_W-1:0]  rd_two;
    logic [PIX_W-1:0]  up1;
    logic [PIX_W-1:0]  up2;

    logic [PIX_W-1:0]  win_l_reg [3];
    logic [PIX_W-1:0]  win_m_reg [3];

    logic [SUM_W-1:0]  sum_right;
    logic [SUM_W-1:0]  sum_left;
    logic [SUM_W-1:0]  sum_lower;
    logic [SUM_W-1:0]  sum_upper;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;

    logic              out_valid_reg;
    logic signed [GRAD_W-1:0] grad_x_reg;
    logic signed [GRAD_W-1:0] grad_y_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic              last_reg;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Saturate frame size
    always_comb
    begin
        if (image_width_reg < CFG_W'(3))
            w_eff = WCMP'(3);
        else if (WCMP'(image_width_reg) > WCMP'(MAX_WIDTH))
            w_eff = WCMP'(MAX_WIDTH);
        else
            w_eff = WCMP'(image_width_reg);

        if (image_height_reg < CFG_W'(3))
            h_eff = HCMP'(3);
        else if (HCMP'(image_height_reg) > HCMP'(MAX_HEIGHT))
            h_eff = HCMP'(MAX_HEIGHT);
        else
            h_eff = HCMP'(image_height_reg);
    end

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && (!s1_emit_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    // Position of the incoming pixel
    always_comb
    begin
        c_cur    = frame_start ? '0 : col_reg;
        r_cur    = frame_start ? '0 : row_reg;
        c_ext    = WCMP'(c_cur);
        r_ext    = HCMP'(r_cur);
        c_inc    = c_ext + WCMP'(1);
        r_inc    = r_ext + HCMP'(1);
        col_less = COL_OW'(c_cur) - COL_OW'(1);
        row_less = ROW_OW'(r_cur) - ROW_OW'(1);
        emit     = (c_ext >= WCMP'(2)) && (r_ext >= HCMP'(2)) &&
                   (c_ext < w_eff) && (r_ext < h_eff);
        last_pix = (c_ext == w_eff - WCMP'(1)) && (r_ext == h_eff - HCMP'(1));

        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : RW'(r_inc);
        end
        else
        begin
            col_next = CW'(c_inc);
            row_next = r_cur;
        end
        fwd_next = s1_move && (c_cur == s1_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffers
    sobg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (rd_above)
    );

    sobg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_idx_reg),
        .wr_data (up1),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (rd_two)
    );

    assign up1 = fwd_reg ? fwd_above_reg : rd_above;
    assign up2 = fwd_reg ? fwd_two_reg   : rd_two;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= fwd_next;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg   <= emit;
            s1_last_reg   <= last_pix;
            s1_px_reg     <= pixel;
            s1_idx_reg    <= c_cur;
            s1_row_reg    <= row_less[COORD_W-1:0];
            s1_col_reg    <= col_less[COORD_W-1:0];
            fwd_above_reg <= s1_px_reg;
            fwd_two_reg   <= up1;
        end
    end

    // Window columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_l_reg[k] <= '0;
                win_m_reg[k] <= '0;
            end
        end
        else if (s1_move)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_l_reg[k] <= win_m_reg[k];
            end
            win_m_reg[0] <= up2;
            win_m_reg[1] <= up1;
            win_m_reg[2] <= s1_px_reg;
        end
    end

    // Gradients
    always_comb
    begin
        sum_right = SUM_W'(up2) + {1'b0, up1, 1'b0} + SUM_W'(s1_px_reg);
        sum_left  = SUM_W'(win_l_reg[0]) + {1'b0, win_l_reg[1], 1'b0} +
                    SUM_W'(win_l_reg[2]);
        sum_lower = SUM_W'(win_l_reg[2]) + {1'b0, win_m_reg[2], 1'b0} +
                    SUM_W'(s1_px_reg);
        sum_upper = SUM_W'(win_l_reg[0]) + {1'b0, win_m_reg[0], 1'b0} +
                    SUM_W'(up2);
        gx = signed'({1'b0, sum_right}) - signed'({1'b0, sum_left});
        gy = signed'({1'b0, sum_lower}) - signed'({1'b0, sum_upper});
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit_reg)
        begin
            grad_x_reg  <= gx;
            grad_y_reg  <= gy;
            out_row_reg <= s1_row_reg;
            out_col_reg <= s1_col_reg;
            last_reg    <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign grad_x    = grad_x_reg;
    assign grad_y    = grad_y_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

    // Assertions
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input stage");

    a_hold_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> (s1_emit_reg && out_valid_reg && out_stall))
        else $error("input stage held without a blocked result");

    a_fwd_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("line buffer bypass set without an item");

    a_last_is_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_emit_reg)
        else $error("last pixel flagged without a result");

endmodule

FILE: tb/sobel_gradient_3x3_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 3x3 Sobel gradient core.
module sobel_gradient_3x3_core_test;
    import sobg_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [APB_AW-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic                     last;
    } gradient_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [PIX_W-1:0]         pixel = '0;
    logic                     frame_start = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [COORD_W-1:0]       out_row;
    logic [COORD_W-1:0]       out_col;
    logic                     last;

    gradient_t        pending_gradients[$];
    logic [PIX_W-1:0] prev_row [MAX_WIDTH];
    logic [PIX_W-1:0] prev_prev_row [MAX_WIDTH];
    logic [PIX_W-1:0] kernel_px [3][3];
    int unsigned      pos_row = 0;
    int unsigned      pos_col = 0;
    logic [CFG_W-1:0] cfg_width = IMAGE_WIDTH_RST;
    logic [CFG_W-1:0] cfg_height = IMAGE_HEIGHT_RST;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b0;
    bit  restart_pending = 1'b0;

    sobel_gradient_3x3_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .out_row     (out_row),
        .out_col     (out_col),
        .last        (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[sobel_gradient_3x3_core] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic int frame_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    task automatic compute_gradients(input logic [PIX_W-1:0] px, input logic restart);
        int          w;
        int          h;
        int unsigned r;
        int unsigned c;
        int          gx;
        int          gy;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        gradient_t   g;
        w = frame_dim(cfg_width, MAX_WIDTH);
        h = frame_dim(cfg_height, MAX_HEIGHT);
        if (restart)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        up2 = prev_prev_row[c % MAX_WIDTH];
        up1 = prev_row[c % MAX_WIDTH];
        prev_prev_row[c % MAX_WIDTH] = up1;
        prev_row[c % MAX_WIDTH] = px;
        for (int k = 0; k < 3; k++)
        begin
            kernel_px[k][0] = kernel_px[k][1];
            kernel_px[k][1] = kernel_px[k][2];
        end
        kernel_px[0][2] = up2;
        kernel_px[1][2] = up1;
        kernel_px[2][2] = px;
        if (r >= 2 && c >= 2 && r < h && c < w)
        begin
            gx = (int'(kernel_px[0][2]) + 2 * int'(kernel_px[1][2]) + int'(kernel_px[2][2]))
               - (int'(kernel_px[0][0]) + 2 * int'(kernel_px[1][0]) + int'(kernel_px[2][0]));
            gy = (int'(kernel_px[2][0]) + 2 * int'(kernel_px[2][1]) + int'(kernel_px[2][2]))
               - (int'(kernel_px[0][0]) + 2 * int'(kernel_px[0][1]) + int'(kernel_px[0][2]));
            g.gx   = gx[GRAD_W-1:0];
            g.gy   = gy[GRAD_W-1:0];
            g.row  = COORD_W'(r - 1);
            g.col  = COORD_W'(c - 1);
            g.last = (r == h - 1) && (c == w - 1);
            pending_gradients.push_back(g);
        end
        if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            pos_col = c + 1;
    endtask

    task automatic check_gradient;
        gradient_t want;
        if (pending_gradients.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction at (%0d,%0d)", out_row, out_col));
            return;
        end
        want = pending_gradients.pop_front();
        if (grad_x !== want.gx)
            report_mismatch($sformatf("grad_x at (%0d,%0d): got %0d, want %0d",
                                      want.row, want.col, grad_x, want.gx));
        if (grad_y !== want.gy)
            report_mismatch($sformatf("grad_y at (%0d,%0d): got %0d, want %0d",
                                      want.row, want.col, grad_y, want.gy));
        if (out_row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, want %0d", out_col, want.col));
        if (last !== want.last)
            report_mismatch($sformatf("last at (%0d,%0d): got %b, want %b",
                                      want.row, want.col, last, want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            check_gradient();
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 10)
        begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value, input logic mark);
        logic fs;
        fs = mark | restart_pending;
        restart_pending = 1'b0;
        if (idle_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= value;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        compute_gradients(value, fs);
    endtask

    task automatic send_random_pixels(input int count, input bit mark_first, input int noise_pct);
        bit               extremes;
        logic [PIX_W-1:0] value;
        extremes = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < count; i++)
        begin
            if (extremes)
                value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                value = PIX_W'($urandom_range(0, 255));
            send_pixel(value, (i == 0 && mark_first) || ($urandom_range(0, 99) < noise_pct));
        end
    endtask

    task automatic wait_results_drained;
        in_valid <= 1'b0;
        while (pending_gradients.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
        logic [APB_DW-1:0] noise;
        logic [APB_DW-1:0] readback;
        int                old_w;
        wait_results_drained();
        old_w = frame_dim(cfg_width, MAX_WIDTH);
        noise = $urandom();
        apb_write(WIDTH_ADDR, {noise[APB_DW-1:CFG_W], w_val});
        cfg_width = w_val;
        noise = $urandom();
        apb_write(HEIGHT_ADDR, {noise[APB_DW-1:CFG_W], h_val});
        cfg_height = h_val;
        apb_read(WIDTH_ADDR, readback);
        if (readback !== {{(APB_DW-CFG_W){1'b0}}, w_val})
            report_mismatch($sformatf("image_width reads %0d, want %0d", readback, w_val));
        apb_read(HEIGHT_ADDR, readback);
        if (readback !== {{(APB_DW-CFG_W){1'b0}}, h_val})
            report_mismatch($sformatf("image_height reads %0d, want %0d", readback, h_val));
        // restart the frame when rows widen mid-frame so no unwritten buffer entry is used
        if (frame_dim(cfg_width, MAX_WIDTH) > old_w && (pos_row != 0 || pos_col != 0))
            restart_pending = 1'b1;
    endtask

    task automatic test_register_access;
        logic [APB_DW-1:0] readback;
        apb_read(WIDTH_ADDR, readback);
        if (readback !== {{(APB_DW-CFG_W){1'b0}}, IMAGE_WIDTH_RST})
            report_mismatch($sformatf("image_width after reset reads %0d", readback));
        apb_read(HEIGHT_ADDR, readback);
        if (readback !== {{(APB_DW-CFG_W){1'b0}}, IMAGE_HEIGHT_RST})
            report_mismatch($sformatf("image_height after reset reads %0d", readback));
        set_frame_size(11'd1024, 11'd1024);
    endtask

    task automatic test_gradient_extremes;
        logic [PIX_W-1:0] value;
        idle_on = 1'b1;
        set_frame_size(11'd4, 11'd3);
        for (int i = 0; i < 12; i++)
        begin
            value = (i % 4 == 1 || i % 4 == 2) ? 8'hFF : 8'h00;
            send_pixel(value, i == 0);
        end
        // width below the minimum saturates to 3; frame follows without frame_start
        set_frame_size(11'd2, 11'd4);
        for (int i = 0; i < 12; i++)
        begin
            value = (i < 3 || i >= 9) ? 8'hFF : 8'h00;
            send_pixel(value, 1'b0);
        end
    endtask

    task automatic test_midframe_changes;
        idle_on = 1'b1;
        set_frame_size(11'd5, 11'd5);
        send_random_pixels(18, 1'b1, 0);
        set_frame_size(11'd3, 11'd3);
        send_random_pixels(1, 1'b0, 0);
        send_random_pixels(2, 1'b0, 0);
        send_random_pixels(9, 1'b1, 0);
    endtask

    task automatic test_large_frames;
        idle_on = 1'b1;
        set_frame_size(11'd2047, 11'd0);
        send_random_pixels(128, 1'b1, 0);
        idle_on = 1'b0;
        set_frame_size(11'd1, 11'd1500);
        send_random_pixels(120, 1'b1, 0);
    endtask

    task automatic test_random_frames(input int total);
        int sent;
        int sel;
        int w_raw;
        int h_raw;
        int area;
        int n;
        sent = 0;
        while (sent < total)
        begin
            sel = $urandom_range(0, 19);
            w_raw = (sel == 0) ? $urandom_range(0, 2)
                  : (sel < 3)  ? $urandom_range(13, 40) : $urandom_range(3, 12);
            sel = $urandom_range(0, 19);
            h_raw = (sel == 0) ? $urandom_range(0, 2)
                  : (sel < 3)  ? $urandom_range(9, 20) : $urandom_range(3, 8);
            idle_on = (sent < total * 4 / 5) ? ($urandom_range(0, 3) != 0) : 1'b0;
            set_frame_size(w_raw[CFG_W-1:0], h_raw[CFG_W-1:0]);
            repeat ($urandom_range(1, 3))
            begin
                area = frame_dim(cfg_width, MAX_WIDTH) * frame_dim(cfg_height, MAX_HEIGHT);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area - 1) : area;
                send_random_pixels(n, $urandom_range(0, 3) != 0, 2);
                sent += n;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_gradient_extremes();
        test_midframe_changes();
        test_large_frames();
        test_random_frames(550);
        idle_on = 1'b0;
        wait_results_drained();
        if (mismatch_count == 0)
            $display("[sobel_gradient_3x3_core] OK");
        else
            $display("[sobel_gradient_3x3_core] ERROR");
        $finish;
    end

endmodule
